// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("%m: invariant check failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_ALWAYS(label, cond)
`endif

`endif

// File: hdl/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg
// Shared types, constants, coefficient tables and the ratio^1.4 ROM builder.
// ----------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

    localparam int POW_TABLE_DEPTH = 256;
    localparam int POW_IDX_W       = $clog2(POW_TABLE_DEPTH);

    localparam int CNT_W   = 16;
    localparam int RATIO_W = 17;
    localparam int COEF_W  = 20;
    localparam int PROD_W  = 36;
    localparam int MUL_W   = 17;
    localparam int TRUNC_W = 33;
    localparam int SCALE_W = 25;
    localparam int LUXW_W  = 26;
    localparam int LUX_W   = 24;

    localparam int DIV_STAGES = RATIO_W;

    localparam logic [CNT_W-1:0] FULL_SCALE = 16'hFFFF;
    localparam logic [LUX_W-1:0] LUX_MAX    = 24'hFFFFFF;

    localparam logic [RATIO_W-1:0] THR_POW_STD = 17'd32768;
    localparam logic [RATIO_W-1:0] THR_POW_CS  = 17'd34079;
    localparam logic [RATIO_W-1:0] THR_MID_STD = 17'd39977;
    localparam logic [RATIO_W-1:0] THR_MID_CS  = 17'd42598;
    localparam logic [RATIO_W-1:0] THR_HIGH    = 17'd52429;
    localparam logic [RATIO_W-1:0] THR_TOP     = 17'd85197;

    localparam logic [SCALE_W-1:0] SCALE_13MS  = 25'd1923027;
    localparam logic [SCALE_W-1:0] SCALE_100MS = 25'd263455;
    localparam logic [SCALE_W-1:0] SCALE_402MS = 25'd65536;

    localparam logic [MUL_W-1:0] MUL_UNITY = 17'h10000;

    // integration time codes
    localparam logic [1:0] ISEL_13MS  = 2'd0;
    localparam logic [1:0] ISEL_100MS = 2'd1;
    localparam logic [1:0] ISEL_402MS = 2'd2;
    localparam logic [1:0] ISEL_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_HIGH_GAIN  = 2'd0;
    localparam logic [1:0] CFG_INT_SEL    = 2'd1;
    localparam logic [1:0] CFG_CHIP_SCALE = 2'd2;

    typedef enum logic [1:0] {
        SEG_POW,
        SEG_MID,
        SEG_HIGH,
        SEG_TOP
    } t_seg;

    typedef struct packed {
        logic       high_gain;
        logic [1:0] int_sel;
        logic       chip_scale;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]   full;
        logic [CNT_W-1:0]   ir;
        logic [RATIO_W-1:0] ratio;
        logic               sat;
        logic               kill;
    } t_ratio_item;

    typedef struct packed {
        logic [PROD_W-1:0] diff;
        logic [MUL_W-1:0]  mul;
        logic              sat;
        logic              kill;
    } t_diff_item;

    typedef logic [POW_IDX_W-1:0] t_pow_idx;
    typedef logic [15:0] t_pow_rom [POW_TABLE_DEPTH];

    function automatic logic [COEF_W-1:0] coef_full(input t_seg seg, input logic cs);
        logic [COEF_W-1:0] c;
        case (seg)
            SEG_POW:  c = cs ? 20'd528482 : 20'd510027;
            SEG_MID:  c = cs ? 20'd384198 : 20'd375810;
            SEG_HIGH: c = cs ? 20'd263402 : 20'd214748;
            SEG_TOP:  c = cs ? 20'd56707  : 20'd24495;
            default:  c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [COEF_W-1:0] coef_ir(input t_seg seg, input logic cs);
        logic [COEF_W-1:0] c;
        case (seg)
            SEG_POW:  c = cs ? 20'd994889 : 20'd1040187;
            SEG_MID:  c = cs ? 20'd488217 : 20'd520094;
            SEG_HIGH: c = 20'd256691;
            SEG_TOP:  c = cs ? 20'd43621  : 20'd18790;
            default:  c = '0;
        endcase
        return c;
    endfunction

    // x^1.4 in Q0.16 as x * floor(fifth root of x^2 * 2^48) / 2^16
    function automatic t_pow_rom build_pow_rom();
        t_pow_rom     rom;
        logic [31:0]  x;
        logic [31:0]  q;
        logic [16:0]  lo;
        logic [16:0]  hi;
        logic [16:0]  mid;
        logic [127:0] r5;
        logic [127:0] lim;
        for (int i = 0; i < POW_TABLE_DEPTH; i++) begin
            x   = 32'((64'(i) << 16) / POW_TABLE_DEPTH);
            q   = x * x;
            lim = 128'(q) << 48;
            lo  = 17'd0;
            hi  = 17'd65535;
            for (int k = 0; k < 17; k++) begin
                if (lo < hi) begin
                    mid = 17'((lo + hi + 17'd1) >> 1);
                    r5  = 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid);
                    if (r5 <= lim) begin
                        lo = mid;
                    end else begin
                        hi = mid - 17'd1;
                    end
                end
            end
            rom[i] = 16'((64'(x) * 64'(lo)) >> 16);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ambient_light_lux_calc.sv
// ----------------------------------------------------------------------------
// ambient_light_lux_calc: two-channel light counts to lux in Q20.4
// Pipeline: 17 divider stages, 4 segment stages, 3 scaling stages.
// Throughput one count pair per cycle; stalls fill bubbles before back-pressure.
// Synchronous active-low reset empties the pipeline and restores configuration.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ambient_light_lux_calc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [1:0]  i_cfg_data,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [15:0] full_count, [31:16] infrared_count
    // output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // [23:0] lux_q
    output logic [0:0]       o_m_axis_tuser    // [0] saturated
);

    logic       r_high_gain;
    logic [1:0] r_int_sel;
    logic       r_chip_scale;

    alc_pkg::t_cfg        cfg;
    alc_pkg::t_ratio_item ratio_item;
    alc_pkg::t_diff_item  diff_item;
    logic                 div_valid, seg_ready;
    logic                 seg_valid, scale_ready;
    logic                 lux_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_gain  <= 1'b0;
            r_int_sel    <= alc_pkg::ISEL_402MS;
            r_chip_scale <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                alc_pkg::CFG_HIGH_GAIN:  r_high_gain  <= i_cfg_data[0];
                alc_pkg::CFG_INT_SEL:    r_int_sel    <= i_cfg_data;
                alc_pkg::CFG_CHIP_SCALE: r_chip_scale <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.high_gain  = r_high_gain;
    assign cfg.int_sel    = r_int_sel;
    assign cfg.chip_scale = r_chip_scale;

    alc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_full  (i_s_axis_tdata[15:0]),
        .i_ir    (i_s_axis_tdata[31:16]),
        .o_valid (div_valid),
        .i_ready (seg_ready),
        .o_item  (ratio_item)
    );

    alc_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (div_valid),
        .o_ready (seg_ready),
        .i_item  (ratio_item),
        .o_valid (seg_valid),
        .i_ready (scale_ready),
        .o_item  (diff_item)
    );

    alc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (seg_valid),
        .o_ready (scale_ready),
        .i_item  (diff_item),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_lux   (o_m_axis_tdata),
        .o_sat   (lux_sat)
    );

    assign o_m_axis_tuser = lux_sat;

    `ASSERT_IMPLIES(a_sat_zero_lux, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == '0)
    `ASSERT_ALWAYS(a_empty_out_ready, o_m_axis_tvalid || o_s_axis_tready)
    `ASSERT_IMPLIES(a_reset_empty, $rose(i_rst_n), !o_m_axis_tvalid)

endmodule

`default_nettype wire

// File: hdl/alc_div.sv
// ----------------------------------------------------------------------------
// alc_div
// Classifies a count pair and forms infrared/full in Q1.16, one quotient bit
// per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire alc_pkg::t_cfg             i_cfg,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [alc_pkg::CNT_W-1:0] i_full,
    input  wire logic [alc_pkg::CNT_W-1:0] i_ir,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output alc_pkg::t_ratio_item           o_item
);

    localparam int N = alc_pkg::DIV_STAGES;

    typedef struct packed {
        logic [alc_pkg::CNT_W-1:0]   full;
        logic [alc_pkg::CNT_W-1:0]   ir;
        logic                        sat;
        logic                        kill;
        logic [alc_pkg::CNT_W-1:0]   rem;
        logic [alc_pkg::RATIO_W-1:0] quo;
    } t_div_stage;

    t_div_stage r_st [N];
    t_div_stage n_st [N];
    logic [N-1:0] r_vld;
    logic [N-1:0] vld_in;
    wire  [N:0]   stage_en;

    assign stage_en[N] = i_ready;
    for (genvar s = 0; s < N; s++) begin : g_en
        assign stage_en[s] = !r_vld[s] || stage_en[s+1];
    end

    assign vld_in = {r_vld[N-2:0], i_valid};

    always_comb begin
        logic [alc_pkg::CNT_W:0] trial;
        logic                    ge0;
        logic                    over0;
        ge0   = i_ir >= i_full;
        over0 = {1'b0, i_ir} >= {i_full, 1'b0};
        n_st[0].full = i_full;
        n_st[0].ir   = i_ir;
        n_st[0].sat  = (i_full == alc_pkg::FULL_SCALE) || (i_ir == alc_pkg::FULL_SCALE);
        n_st[0].kill = n_st[0].sat || (i_full == '0) ||
                       (i_cfg.int_sel == alc_pkg::ISEL_NONE) || over0;
        n_st[0].rem  = ge0 ? i_ir - i_full : i_ir;
        n_st[0].quo  = {ge0, {(alc_pkg::RATIO_W-1){1'b0}}};
        for (int s = 1; s < N; s++) begin
            n_st[s] = r_st[s-1];
            trial   = {r_st[s-1].rem, 1'b0};
            if (trial >= {1'b0, r_st[s-1].full}) begin
                n_st[s].rem        = alc_pkg::CNT_W'(trial - {1'b0, r_st[s-1].full});
                n_st[s].quo[N-1-s] = 1'b1;
            end else begin
                n_st[s].rem = trial[alc_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < N; s++) begin
                if (stage_en[s]) begin
                    r_vld[s] <= vld_in[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < N; s++) begin
            if (stage_en[s]) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_ready      = stage_en[0];
    assign o_valid      = r_vld[N-1];
    assign o_item.full  = r_st[N-1].full;
    assign o_item.ir    = r_st[N-1].ir;
    assign o_item.ratio = r_st[N-1].quo;
    assign o_item.sat   = r_st[N-1].sat;
    assign o_item.kill  = r_st[N-1].kill;

endmodule

`default_nettype wire

// File: hdl/alc_seg.sv
// ----------------------------------------------------------------------------
// alc_seg
// Picks the ratio segment, reads the ratio^1.4 ROM and forms the unsigned
// segment difference over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_seg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire alc_pkg::t_cfg        i_cfg,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire alc_pkg::t_ratio_item i_item,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output alc_pkg::t_diff_item       o_item
);

    localparam int N = 4;
    localparam alc_pkg::t_pow_rom POW_ROM = alc_pkg::build_pow_rom();

    logic [N-1:0] r_vld;
    logic [N-1:0] vld_in;
    wire  [N:0]   stage_en;

    assign stage_en[N] = i_ready;
    for (genvar s = 0; s < N; s++) begin : g_en
        assign stage_en[s] = !r_vld[s] || stage_en[s+1];
    end

    assign vld_in = {r_vld[N-2:0], i_valid};

    // stage 0: segment and ROM index
    alc_pkg::t_seg              r_s0_seg, n_s0_seg;
    alc_pkg::t_pow_idx          r_s0_idx, n_s0_idx;
    logic [alc_pkg::CNT_W-1:0]  r_s0_full, r_s0_ir;
    logic                       r_s0_sat, r_s0_kill;
    logic [31:0]                idx_prod;

    always_comb begin
        logic cs;
        cs = i_cfg.chip_scale;
        if (i_item.ratio < (cs ? alc_pkg::THR_POW_CS : alc_pkg::THR_POW_STD)) begin
            n_s0_seg = alc_pkg::SEG_POW;
        end else if (i_item.ratio < (cs ? alc_pkg::THR_MID_CS : alc_pkg::THR_MID_STD)) begin
            n_s0_seg = alc_pkg::SEG_MID;
        end else if (i_item.ratio < alc_pkg::THR_HIGH) begin
            n_s0_seg = alc_pkg::SEG_HIGH;
        end else begin
            n_s0_seg = alc_pkg::SEG_TOP;
        end
        idx_prod = 32'(i_item.ratio) * 32'(alc_pkg::POW_TABLE_DEPTH);
        if (idx_prod[31:16] >= 16'(alc_pkg::POW_TABLE_DEPTH)) begin
            n_s0_idx = alc_pkg::t_pow_idx'(alc_pkg::POW_TABLE_DEPTH - 1);
        end else begin
            n_s0_idx = alc_pkg::t_pow_idx'(idx_prod[31:16]);
        end
    end

    // stage 1: ROM read and coefficients
    logic [15:0]                 r_s1_pow;
    logic [alc_pkg::COEF_W-1:0]  r_s1_c0, r_s1_c1;
    logic [alc_pkg::CNT_W-1:0]   r_s1_full, r_s1_ir;
    logic                        r_s1_is_pow, r_s1_sat, r_s1_kill;

    // stage 2: products
    logic [alc_pkg::PROD_W-1:0]  r_s2_p0, r_s2_p1, n_s2_p0, n_s2_p1;
    logic [alc_pkg::MUL_W-1:0]   r_s2_mul;
    logic                        r_s2_sat, r_s2_kill;

    always_comb begin
        logic [alc_pkg::CNT_W-1:0] op;
        op      = r_s1_is_pow ? r_s1_pow : r_s1_ir;
        n_s2_p0 = r_s1_is_pow ? {r_s1_c0, 16'd0} :
                  alc_pkg::PROD_W'(r_s1_c0) * alc_pkg::PROD_W'(r_s1_full);
        n_s2_p1 = alc_pkg::PROD_W'(r_s1_c1) * alc_pkg::PROD_W'(op);
    end

    // stage 3: difference
    logic [alc_pkg::PROD_W-1:0]  r_s3_diff;
    logic [alc_pkg::MUL_W-1:0]   r_s3_mul;
    logic                        r_s3_sat, r_s3_kill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < N; s++) begin
                if (stage_en[s]) begin
                    r_vld[s] <= vld_in[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s0_seg  <= n_s0_seg;
            r_s0_idx  <= n_s0_idx;
            r_s0_full <= i_item.full;
            r_s0_ir   <= i_item.ir;
            r_s0_sat  <= i_item.sat;
            r_s0_kill <= i_item.kill || (i_item.ratio >= alc_pkg::THR_TOP);
        end
        if (stage_en[1]) begin
            r_s1_pow    <= POW_ROM[r_s0_idx];
            r_s1_c0     <= alc_pkg::coef_full(r_s0_seg, i_cfg.chip_scale);
            r_s1_c1     <= alc_pkg::coef_ir(r_s0_seg, i_cfg.chip_scale);
            r_s1_full   <= r_s0_full;
            r_s1_ir     <= r_s0_ir;
            r_s1_is_pow <= r_s0_seg == alc_pkg::SEG_POW;
            r_s1_sat    <= r_s0_sat;
            r_s1_kill   <= r_s0_kill;
        end
        if (stage_en[2]) begin
            r_s2_p0   <= n_s2_p0;
            r_s2_p1   <= n_s2_p1;
            r_s2_mul  <= r_s1_is_pow ? {1'b0, r_s1_full} : alc_pkg::MUL_UNITY;
            r_s2_sat  <= r_s1_sat;
            r_s2_kill <= r_s1_kill;
        end
        if (stage_en[3]) begin
            r_s3_diff <= r_s2_p0 - r_s2_p1;
            r_s3_mul  <= r_s2_mul;
            r_s3_sat  <= r_s2_sat;
            r_s3_kill <= r_s2_kill || (r_s2_p0 <= r_s2_p1);
        end
    end

    assign o_ready     = stage_en[0];
    assign o_valid     = r_vld[N-1];
    assign o_item.diff = r_s3_diff;
    assign o_item.mul  = r_s3_mul;
    assign o_item.sat  = r_s3_sat;
    assign o_item.kill = r_s3_kill;

endmodule

`default_nettype wire

// File: hdl/alc_scale.sv
// ----------------------------------------------------------------------------
// alc_scale
// Scales the segment difference for integration time and gain, zeroes killed
// items, then clamps to the Q20.4 output range.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_scale (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire alc_pkg::t_cfg             i_cfg,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire alc_pkg::t_diff_item       i_item,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [alc_pkg::LUX_W-1:0]      o_lux,
    output logic                           o_sat
);

    localparam int N  = 3;
    localparam int DW = alc_pkg::PROD_W + alc_pkg::MUL_W;
    localparam int SW = alc_pkg::TRUNC_W + alc_pkg::SCALE_W;

    logic [N-1:0] r_vld;
    logic [N-1:0] vld_in;
    wire  [N:0]   stage_en;

    assign stage_en[N] = i_ready;
    for (genvar s = 0; s < N; s++) begin : g_en
        assign stage_en[s] = !r_vld[s] || stage_en[s+1];
    end

    assign vld_in = {r_vld[N-2:0], i_valid};

    logic [DW-1:0]                d_prod;
    logic [alc_pkg::SCALE_W-1:0]  n_s0_scale;
    logic [alc_pkg::TRUNC_W-1:0]  r_s0_trunc;
    logic [alc_pkg::SCALE_W-1:0]  r_s0_scale;
    logic                         r_s0_sat, r_s0_kill;

    logic [SW-1:0]                s_prod;
    logic [alc_pkg::LUXW_W-1:0]   r_s1_lux;
    logic                         r_s1_sat, r_s1_kill;

    logic [alc_pkg::LUX_W-1:0]    r_s2_lux, n_s2_lux;
    logic                         r_s2_sat;

    always_comb begin
        logic [alc_pkg::SCALE_W-1:0] base;
        d_prod = DW'(i_item.diff) * DW'(i_item.mul);
        case (i_cfg.int_sel)
            alc_pkg::ISEL_13MS:  base = alc_pkg::SCALE_13MS;
            alc_pkg::ISEL_100MS: base = alc_pkg::SCALE_100MS;
            default:             base = alc_pkg::SCALE_402MS;
        endcase
        n_s0_scale = i_cfg.high_gain ? base : base << 4;
    end

    always_comb begin
        s_prod = SW'(r_s0_trunc) * SW'(r_s0_scale);
        if (r_s1_kill) begin
            n_s2_lux = '0;
        end else if (r_s1_lux > alc_pkg::LUXW_W'(alc_pkg::LUX_MAX)) begin
            n_s2_lux = alc_pkg::LUX_MAX;
        end else begin
            n_s2_lux = r_s1_lux[alc_pkg::LUX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < N; s++) begin
                if (stage_en[s]) begin
                    r_vld[s] <= vld_in[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s0_trunc <= d_prod[DW-1:20];
            r_s0_scale <= n_s0_scale;
            r_s0_sat   <= i_item.sat;
            r_s0_kill  <= i_item.kill;
        end
        if (stage_en[1]) begin
            r_s1_lux  <= s_prod[SW-1:32];
            r_s1_sat  <= r_s0_sat;
            r_s1_kill <= r_s0_kill;
        end
        if (stage_en[2]) begin
            r_s2_lux <= n_s2_lux;
            r_s2_sat <= r_s1_sat;
        end
    end

    assign o_ready = stage_en[0];
    assign o_valid = r_vld[N-1];
    assign o_lux   = r_s2_lux;
    assign o_sat   = r_s2_sat;

endmodule

`default_nettype wire

// File: sim/ambient_light_lux_calc_checker.sv
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_checker: scoreboard for the lux calculator
// Tracks configuration transfers, predicts lux and saturation for every
// accepted count pair and compares each output transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_light_lux_calc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_pair_valid,
    input  wire logic        i_pair_ready,
    input  wire logic [31:0] i_pair_data,   // [15:0] full_count, [31:16] infrared_count
    input  wire logic        i_lux_valid,
    input  wire logic        i_lux_ready,
    input  wire logic [23:0] i_lux_data,    // [23:0] lux_q
    input  wire logic [0:0]  i_lux_user,    // [0] saturated
    output int               o_fail_count,
    output int               o_pending,
    output int               o_pairs,
    output int               o_saturated,
    output int               o_lit
);

    import alc_pkg::*;

    typedef struct packed {
        logic [23:0] lux;
        logic        sat;
    } t_lux_expect;

    logic [15:0]  pow14_rom [POW_TABLE_DEPTH];
    t_lux_expect  lux_expected [$];
    t_lux_expect  oldest;

    logic         gain_high;
    logic [1:0]   int_sel;
    logic         chip_scale;

    // x^1.4 in Q0.16, with the fifth root found bit by bit from the top
    function automatic logic [15:0] pow14_entry(input int unsigned idx);
        logic [31:0]  x;
        logic [127:0] bound;
        logic [127:0] r5;
        logic [15:0]  root;
        logic [15:0]  trial;
        x     = (idx << 16) / POW_TABLE_DEPTH;
        bound = 128'(x * x) << 48;
        root  = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            r5    = 128'(trial);
            r5    = r5 * trial * trial * trial * trial;
            if (r5 <= bound) begin
                root = trial;
            end
        end
        return 16'((x * root) >> 16);
    endfunction

    function automatic t_lux_expect predict_lux(input logic [15:0] full, input logic [15:0] ir);
        t_lux_expect res;
        logic [63:0] full_w;
        logic [63:0] ir_w;
        logic [63:0] ratio;
        logic [63:0] idx;
        logic [63:0] k_full;
        logic [63:0] k_ir;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] scale;
        logic [63:0] lux_w;
        t_seg        seg;
        logic        in_range;
        res.lux  = '0;
        res.sat  = 1'b0;
        full_w   = 64'(full);
        ir_w     = 64'(ir);
        seg      = SEG_TOP;
        in_range = 1'b1;
        if (full == FULL_SCALE || ir == FULL_SCALE) begin
            res.sat = 1'b1;
        end else if (full != '0 && int_sel != ISEL_NONE) begin
            ratio = (ir_w << 16) / full_w;
            if (ratio < 64'(chip_scale ? THR_POW_CS : THR_POW_STD)) begin
                seg = SEG_POW;
            end else if (ratio < 64'(chip_scale ? THR_MID_CS : THR_MID_STD)) begin
                seg = SEG_MID;
            end else if (ratio < 64'(THR_HIGH)) begin
                seg = SEG_HIGH;
            end else if (ratio < 64'(THR_TOP)) begin
                seg = SEG_TOP;
            end else begin
                in_range = 1'b0;
            end
            case (seg)
                SEG_POW: begin
                    k_full = chip_scale ? 64'd528482 : 64'd510027;
                    k_ir   = chip_scale ? 64'd994889 : 64'd1040187;
                end
                SEG_MID: begin
                    k_full = chip_scale ? 64'd384198 : 64'd375810;
                    k_ir   = chip_scale ? 64'd488217 : 64'd520094;
                end
                SEG_HIGH: begin
                    k_full = chip_scale ? 64'd263402 : 64'd214748;
                    k_ir   = 64'd256691;
                end
                default: begin
                    k_full = chip_scale ? 64'd56707 : 64'd24495;
                    k_ir   = chip_scale ? 64'd43621 : 64'd18790;
                end
            endcase
            a = (k_full * full_w) << 16;
            if (seg == SEG_POW) begin
                idx = (ratio * POW_TABLE_DEPTH) >> 16;
                if (idx >= POW_TABLE_DEPTH) begin
                    idx = POW_TABLE_DEPTH - 1;
                end
                b = k_ir * full_w * 64'(pow14_rom[idx]);
            end else begin
                b = (k_ir * ir_w) << 16;
            end
            if (in_range && a > b) begin
                case (int_sel)
                    ISEL_13MS:  scale = 64'(SCALE_13MS);
                    ISEL_100MS: scale = 64'(SCALE_100MS);
                    default:    scale = 64'(SCALE_402MS);
                endcase
                if (!gain_high) begin
                    scale = scale << 4;
                end
                lux_w = (((a - b) >> 20) * scale) >> 32;
                if (lux_w > 64'(LUX_MAX)) begin
                    lux_w = 64'(LUX_MAX);
                end
                res.lux = lux_w[23:0];
            end
        end
        return res;
    endfunction

    initial begin
        for (int i = 0; i < POW_TABLE_DEPTH; i++) begin
            pow14_rom[i] = pow14_entry(i);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lux_expected.delete();
            gain_high  <= 1'b0;
            int_sel    <= ISEL_402MS;
            chip_scale <= 1'b0;
            o_pending  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HIGH_GAIN:  gain_high  <= i_cfg_data[0];
                    CFG_INT_SEL:    int_sel    <= i_cfg_data;
                    CFG_CHIP_SCALE: chip_scale <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_pair_valid && i_pair_ready) begin
                lux_expected.push_back(predict_lux(i_pair_data[15:0], i_pair_data[31:16]));
                o_pairs++;
            end
            if (i_lux_valid && i_lux_ready) begin
                if (lux_expected.size() == 0) begin
                    $error("unexpected result transfer: lux_q %0d saturated %0d",
                           i_lux_data, i_lux_user[0]);
                    o_fail_count++;
                end else begin
                    oldest = lux_expected.pop_front();
                    if (i_lux_data !== oldest.lux) begin
                        $error("lux_q mismatch: expected %0d, actual %0d",
                               oldest.lux, i_lux_data);
                        o_fail_count++;
                    end
                    if (i_lux_user[0] !== oldest.sat) begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               oldest.sat, i_lux_user[0]);
                        o_fail_count++;
                    end
                    if (oldest.sat) begin
                        o_saturated++;
                    end
                    if (oldest.lux != '0) begin
                        o_lit++;
                    end
                end
            end
            o_pending <= lux_expected.size();
        end
    end

endmodule

`default_nettype wire

// File: sim/ambient_light_lux_calc_tb.sv
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_tb: stimulus and verdict for the lux calculator
// Sends directed count pairs at the segment thresholds and extremes, then
// random pairs under every gain, integration time and package setting, with
// bursty input and a receiver that stalls in several styles.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_light_lux_calc_tb;

    import alc_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_PAIRS   = 72;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {
        READY_STEADY,
        READY_COIN,
        READY_RARE_STALL,
        READY_LONG_STALL
    } t_ready_style;

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [1:0]   cfg_index = CFG_HIGH_GAIN;
    logic [1:0]   cfg_data  = 2'b00;
    logic         s_valid   = 1'b0;
    logic [31:0]  s_data    = '0;
    logic         m_ready   = 1'b0;
    logic         cfg_ready;
    logic         s_ready;
    logic         m_valid;
    logic [23:0]  m_data;
    logic [0:0]   m_user;

    int           fail_count;
    int           pending;
    int           pairs_sent;
    int           saturated_seen;
    int           lit_seen;
    int           burst_left    = 0;
    int           idle_cycles   = 0;
    int           settings_seen = 0;
    t_ready_style ready_style   = READY_STEADY;
    int           style_left    = 0;
    int           stall_left    = 0;

    ambient_light_lux_calc dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    ambient_light_lux_calc_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_pair_valid (s_valid),
        .i_pair_ready (s_ready),
        .i_pair_data  (s_data),
        .i_lux_valid  (m_valid),
        .i_lux_ready  (m_ready),
        .i_lux_data   (m_data),
        .i_lux_user   (m_user),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pairs      (pairs_sent),
        .o_saturated  (saturated_seen),
        .o_lit        (lit_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (style_left == 0) begin
            ready_style <= t_ready_style'($urandom_range(0, 3));
            style_left  <= $urandom_range(30, 200);
        end else begin
            style_left <= style_left - 1;
        end
        case (ready_style)
            READY_STEADY:     m_ready <= 1'b1;
            READY_COIN:       m_ready <= 1'($urandom_range(0, 1));
            READY_RARE_STALL: m_ready <= ($urandom_range(0, 7) != 0);
            default: begin
                if (stall_left != 0) begin
                    stall_left <= stall_left - 1;
                    m_ready    <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_left <= $urandom_range(1, 20);
                    m_ready    <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pair(input logic [15:0] full, input logic [15:0] ir);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= {ir, full};
        do @(posedge clk); while (!s_ready);
    endtask

    // hold the input until every expected result has left the block
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic gain, input logic [1:0] isel, input logic cs);
        drain();
        write_reg(CFG_INT_SEL, isel);
        write_reg(CFG_HIGH_GAIN, {1'b0, gain});
        write_reg(CFG_CHIP_SCALE, {1'b0, cs});
        cfg_valid <= 1'b0;
        settings_seen++;
    endtask

    function automatic logic [31:0] random_pair();
        logic [15:0] full;
        logic [15:0] ir;
        logic [63:0] ratio;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        full = 16'($urandom);
        ir   = 16'($urandom);
        if (pick < 45) begin
            if ($urandom_range(0, 3) == 0) begin
                full = 16'($urandom_range(1, 300));
            end else if (full == FULL_SCALE) begin
                full = 16'hFFFE;
            end
            case ($urandom_range(0, 7))
                0:       ratio = 64'(THR_POW_STD);
                1:       ratio = 64'(THR_POW_CS);
                2:       ratio = 64'(THR_MID_STD);
                3:       ratio = 64'(THR_MID_CS);
                4:       ratio = 64'(THR_HIGH);
                5:       ratio = 64'(THR_TOP);
                6:       ratio = 64'd65536;
                default: ratio = 64'($urandom_range(0, 90000)) + 64'd32;
            endcase
            ratio = ratio + $urandom_range(0, 64) - 64'd32;
            ratio = (64'(full) * ratio) >> 16;
            ir    = (ratio > 64'd65534) ? 16'hFFFE : ratio[15:0];
        end else if (pick < 65) begin
            // both counts fully random
        end else if (pick < 75) begin
            full = 16'($urandom_range(0, 15));
            ir   = 16'($urandom_range(0, 15));
        end else if (pick < 85) begin
            case ($urandom_range(0, 2))
                0:       full = FULL_SCALE;
                1:       ir   = FULL_SCALE;
                default: begin
                    full = FULL_SCALE;
                    ir   = FULL_SCALE;
                end
            endcase
        end else if (pick < 90) begin
            full = '0;
        end else begin
            full = 16'hFFFE - 16'($urandom_range(0, 3));
            ir   = 16'($urandom_range(0, full));
        end
        return {ir, full};
    endfunction

    initial begin : stimulus
        logic [31:0] pair;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_pair(16'd0, 16'd0);
        send_pair(16'd0, 16'd1234);
        send_pair(16'hFFFF, 16'd0);
        send_pair(16'd0, 16'hFFFF);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'hFFFE, 16'hFFFE);
        send_pair(16'd1, 16'd0);
        send_pair(16'hFFFE, 16'd0);
        send_pair(16'd1, 16'd1);
        send_pair(16'd3, 16'd4);
        send_pair(16'd1, 16'hFFFE);
        send_pair(16'd1000, 16'd499);
        send_pair(16'd1000, 16'd500);
        send_pair(16'd1000, 16'd610);
        send_pair(16'd1000, 16'd611);
        send_pair(16'd1000, 16'd799);
        send_pair(16'd1000, 16'd800);
        send_pair(16'd1000, 16'd801);
        send_pair(16'd1000, 16'd1300);
        send_pair(16'd1000, 16'd1301);
        send_pair(16'd32768, 16'd16384);
        send_pair(16'hAAAA, 16'h5555);
        send_pair(16'h5555, 16'h2AAA);

        for (int phase = 0; phase < 16; phase++) begin
            apply_setting(phase[0], phase[2:1], phase[3]);
            for (int n = 0; n < PHASE_PAIRS; n++) begin
                if (n == PHASE_PAIRS / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) begin
                    drain();
                end
                pair = random_pair();
                send_pair(pair[15:0], pair[31:16]);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d count pairs over %0d register settings", pairs_sent,
                 settings_seen + 1);
        $display("results: %0d saturated, %0d with nonzero lux", saturated_seen, lit_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/alc_pkg.sv
hdl/alc_div.sv
hdl/alc_seg.sv
hdl/alc_scale.sv
hdl/ambient_light_lux_calc.sv
sim/ambient_light_lux_calc_checker.sv
sim/ambient_light_lux_calc_tb.sv
